@@ src/edf_periodic_task_scheduler_defines.svh @@
// Assertion macros shared by the scheduler RTL.
`ifndef EDF_PERIODIC_TASK_SCHEDULER_DEFINES_SVH
`define EDF_PERIODIC_TASK_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
`define EDFS_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error("check failed");
`define EDFS_ASSERT_NXT(lbl, ck, rn, a, b) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (b)) else $error("check failed");
`else
`define EDFS_ASSERT(lbl, ck, rn, prop)
`define EDFS_ASSERT_NXT(lbl, ck, rn, a, b)
`endif
`endif

@@ src/edfs_pkg.sv @@
package edfs_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_TASKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_TIME     = 1'b1;

  localparam logic [47:0] SUM48_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [15:0] need;
    logic [15:0] period;
    logic [15:0] limit;
    logic [31:0] release_t;
    logic [15:0] progress;
    logic [15:0] issued;
  } task_entry_t;

  localparam int ENTRY_W = $bits(task_entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RUN_RD,
    S_RUN_EX,
    S_MISS,
    S_FIN,
    S_OUT
  } state_t;

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    sat_inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

@@ src/edfs_ram.sv @@
module edfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/edf_periodic_task_scheduler.sv @@
// Channel   Direction  Handshake            Contents
// in_       input      in_valid/in_stall    op, task_slot, exec_need, task_period, job_limit
// out_      output     out_valid/out_stall  running slot, flags, misses, running totals
// cfg_      input      cfg_valid/cfg_ready  register index and 32-bit data
// A load request writes the task RAM when accepted, if its slot is below MAX_TASKS, then
// loads its result into the output register. A tick request scans the active entries over
// the single task RAM read port, updates the running entry if one was found, scans again
// for misses, drains the waiting-time pipeline and loads the output register; past the end
// time it skips to the output register. The next request is taken in the cycle after the load.
// Reset clears control and totals only; the task RAM is not cleared.
// The result sits in an output register, so a new request is taken while it is stalled.
`include "edf_periodic_task_scheduler_defines.svh"
module edf_periodic_task_scheduler
  import edfs_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_op,
  input  logic [3:0]           in_task_slot,
  input  logic [15:0]          in_exec_need,
  input  logic [15:0]          in_task_period,
  input  logic [15:0]          in_job_limit,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           out_running_slot,
  output logic                 out_cpu_busy,
  output logic                 out_job_finished,
  output logic [4:0]           out_misses_now,
  output logic [31:0]          out_completed_total,
  output logic [31:0]          out_missed_total,
  output logic [47:0]          out_waiting_total,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic          rvld_r, rvld_nxt;
  logic [IW-1:0] ridx_r, ridx_nxt;
  logic          found_r, found_nxt;
  logic [IW-1:0] best_r, best_nxt;
  logic [32:0]   best_dl_r, best_dl_nxt;
  logic [31:0]   tick_r, tick_nxt;
  logic          past_end_r, past_end_nxt;
  logic [31:0]   comp_r, comp_nxt;
  logic [31:0]   miss_r, miss_nxt;
  logic [47:0]   wsum_r, wsum_nxt;
  logic [4:0]    misses_r, misses_nxt;
  logic          fin_r, fin_nxt;
  logic          busy_r, busy_nxt;
  logic [4:0]    active_r;
  logic [31:0]   end_r;
  logic          wa_vld_r, wa_vld_nxt;
  logic [31:0]   wa_rel_r, wa_rel_nxt;
  logic [15:0]   wa_used_r, wa_used_nxt;
  logic          wb_vld_r;
  logic [32:0]   wb_w_r, wb_w_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [3:0]    out_slot_r, out_slot_nxt;
  logic          out_busy_r, out_busy_nxt;
  logic          out_fin_r, out_fin_nxt;
  logic [4:0]    out_misses_r, out_misses_nxt;
  logic [31:0]   out_comp_r, out_comp_nxt;
  logic [31:0]   out_miss_r, out_miss_nxt;
  logic [47:0]   out_wsum_r, out_wsum_nxt;

  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  task_entry_t       ent, ent_w, ent_ld;
  logic [32:0]       dl;
  logic [32:0]       diff;
  logic [48:0]       sum49;
  logic [CW-1:0]     n_sat;

  edfs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TASKS)
  ) u_task_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign ent       = task_entry_t'(ram_rdata);
  assign dl        = {1'b0, ent.release_t} + {17'd0, ent.period};

  assign out_valid           = out_valid_r;
  assign out_running_slot    = out_slot_r;
  assign out_cpu_busy        = out_busy_r;
  assign out_job_finished    = out_fin_r;
  assign out_misses_now      = out_misses_r;
  assign out_completed_total = out_comp_r;
  assign out_missed_total    = out_miss_r;
  assign out_waiting_total   = out_wsum_r;

  always_comb begin
    if (32'(active_r) > 32'(MAX_TASKS)) begin
      n_sat = CW'(MAX_TASKS);
    end else begin
      n_sat = CW'(active_r);
    end
  end

  // Waiting time is computed one stage ahead of the saturating accumulate.
  always_comb begin
    diff = {1'b0, tick_r} - {1'b0, wa_rel_r};
    if (!diff[32] && (diff[31:0] >= {16'd0, wa_used_r})) begin
      wb_w_nxt = diff - {17'd0, wa_used_r};
    end else begin
      wb_w_nxt = '0;
    end
    sum49 = {1'b0, wsum_r} + {16'd0, wb_w_r};
    if (!wb_vld_r) begin
      wsum_nxt = wsum_r;
    end else if (sum49[48]) begin
      wsum_nxt = SUM48_MAX;
    end else begin
      wsum_nxt = sum49[47:0];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    n_nxt        = n_r;
    rvld_nxt     = 1'b0;
    ridx_nxt     = ridx_r;
    found_nxt    = found_r;
    best_nxt     = best_r;
    best_dl_nxt  = best_dl_r;
    tick_nxt     = tick_r;
    past_end_nxt = past_end_r;
    comp_nxt     = comp_r;
    miss_nxt     = miss_r;
    misses_nxt   = misses_r;
    fin_nxt      = fin_r;
    busy_nxt     = busy_r;
    wa_vld_nxt   = 1'b0;
    wa_rel_nxt   = wa_rel_r;
    wa_used_nxt  = wa_used_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = '0;
    ram_raddr    = '0;
    ent_w        = ent;
    ent_ld       = '0;
    ram_wdata    = ent_w;
    out_valid_nxt  = out_valid_r & out_stall;
    out_slot_nxt   = out_slot_r;
    out_busy_nxt   = out_busy_r;
    out_fin_nxt    = out_fin_r;
    out_misses_nxt = out_misses_r;
    out_comp_nxt   = out_comp_r;
    out_miss_nxt   = out_miss_r;
    out_wsum_nxt   = out_wsum_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          busy_nxt   = 1'b0;
          fin_nxt    = 1'b0;
          misses_nxt = '0;
          best_nxt   = '0;
          found_nxt  = 1'b0;
          cnt_nxt    = '0;
          n_nxt      = n_sat;
          state_nxt  = S_OUT;
          if (in_op == OP_LOAD) begin
            ent_ld.need     = in_exec_need;
            ent_ld.period   = in_task_period;
            ent_ld.limit    = in_job_limit;
            ram_we    = (32'(in_task_slot) < 32'(MAX_TASKS));
            ram_waddr = IW'(in_task_slot);
            ram_wdata = ent_ld;
          end else if (!past_end_r && (tick_r <= end_r)) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cnt_r < n_r) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_r[IW-1:0];
          rvld_nxt  = 1'b1;
          ridx_nxt  = cnt_r[IW-1:0];
          cnt_nxt   = cnt_r + CW'(1);
        end
        if (rvld_r && (ent.release_t < tick_r) && (ent.issued < ent.limit) &&
            (!found_r || (dl < best_dl_r))) begin
          found_nxt   = 1'b1;
          best_nxt    = ridx_r;
          best_dl_nxt = dl;
        end
        if ((cnt_r == n_r) && !rvld_r) begin
          cnt_nxt   = '0;
          state_nxt = found_r ? S_RUN_RD : S_MISS;
        end
      end
      S_RUN_RD: begin
        ram_re    = 1'b1;
        ram_raddr = best_r;
        state_nxt = S_RUN_EX;
      end
      S_RUN_EX: begin
        busy_nxt       = 1'b1;
        ent_w.progress = ent.progress + 16'd1;
        if (ent_w.progress == ent.need) begin
          fin_nxt         = 1'b1;
          comp_nxt        = sat_inc32(comp_r);
          wa_vld_nxt      = 1'b1;
          wa_rel_nxt      = ent.release_t;
          wa_used_nxt     = ent.need;
          ent_w.release_t = ent.release_t + {16'd0, ent.period};
          ent_w.progress  = '0;
          ent_w.issued    = ent.issued + 16'd1;
        end
        ram_we    = 1'b1;
        ram_waddr = best_r;
        ram_wdata = ent_w;
        cnt_nxt   = '0;
        state_nxt = S_MISS;
      end
      S_MISS: begin
        if (cnt_r < n_r) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_r[IW-1:0];
          rvld_nxt  = 1'b1;
          ridx_nxt  = cnt_r[IW-1:0];
          cnt_nxt   = cnt_r + CW'(1);
        end
        if (rvld_r && (dl <= {1'b0, tick_r}) && (ent.issued < ent.limit)) begin
          wa_vld_nxt      = 1'b1;
          wa_rel_nxt      = ent.release_t;
          wa_used_nxt     = ent.progress;
          miss_nxt        = sat_inc32(miss_r);
          misses_nxt      = misses_r + 5'd1;
          ent_w.release_t = ent.release_t + {16'd0, ent.period};
          ent_w.progress  = '0;
          ent_w.issued    = ent.issued + 16'd1;
          ram_we          = 1'b1;
          ram_waddr       = ridx_r;
          ram_wdata       = ent_w;
        end
        if ((cnt_r == n_r) && !rvld_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!wa_vld_r && !wb_vld_r) begin
          if (tick_r == 32'hFFFF_FFFF) begin
            past_end_nxt = 1'b1;
          end else begin
            tick_nxt = tick_r + 32'd1;
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = 4'(best_r);
          out_busy_nxt   = busy_r;
          out_fin_nxt    = fin_r;
          out_misses_nxt = misses_r;
          out_comp_nxt   = comp_r;
          out_miss_nxt   = miss_r;
          out_wsum_nxt   = wsum_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rvld_r      <= 1'b0;
      wa_vld_r    <= 1'b0;
      wb_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      tick_r      <= 32'd1;
      past_end_r  <= 1'b0;
      comp_r      <= '0;
      miss_r      <= '0;
      wsum_r      <= '0;
      active_r    <= '0;
      end_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      rvld_r      <= rvld_nxt;
      wa_vld_r    <= wa_vld_nxt;
      wb_vld_r    <= wa_vld_r;
      out_valid_r <= out_valid_nxt;
      tick_r      <= tick_nxt;
      past_end_r  <= past_end_nxt;
      comp_r      <= comp_nxt;
      miss_r      <= miss_nxt;
      wsum_r      <= wsum_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ACTIVE_TASKS: active_r <= cfg_data[4:0];
          CFG_END_TIME:     end_r    <= cfg_data;
          default:          active_r <= active_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    n_r          <= n_nxt;
    ridx_r       <= ridx_nxt;
    found_r      <= found_nxt;
    best_r       <= best_nxt;
    best_dl_r    <= best_dl_nxt;
    misses_r     <= misses_nxt;
    fin_r        <= fin_nxt;
    busy_r       <= busy_nxt;
    wa_rel_r     <= wa_rel_nxt;
    wa_used_r    <= wa_used_nxt;
    wb_w_r       <= wb_w_nxt;
    out_slot_r   <= out_slot_nxt;
    out_busy_r   <= out_busy_nxt;
    out_fin_r    <= out_fin_nxt;
    out_misses_r <= out_misses_nxt;
    out_comp_r   <= out_comp_nxt;
    out_miss_r   <= out_miss_nxt;
    out_wsum_r   <= out_wsum_nxt;
  end

  `EDFS_ASSERT(a_out_from_out_state, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == S_OUT))
  `EDFS_ASSERT(a_wait_drained_idle, clk, rst_n, (state_r == S_IDLE) |-> (!wa_vld_r && !wb_vld_r))
  `EDFS_ASSERT(a_no_ram_collision, clk, rst_n, (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
  `EDFS_ASSERT_NXT(a_fin_then_out, clk, rst_n, (state_r == S_FIN) && !wa_vld_r && !wb_vld_r, state_r == S_OUT)

endmodule
